@@ hdl/drs_pkg.sv @@
// shared types and constants of the dtr/rts auto-reset sequencer
`timescale 1ns / 1ps

package drs_pkg;

  // register reset values
  localparam logic [15:0] HOLD_MS_RST   = 16'd25;
  localparam logic [15:0] SETTLE_MS_RST = 16'd50;
  localparam logic [15:0] IDLE_MS_RST   = 16'd1000;
  localparam logic [15:0] WAKE_MS_RST   = 16'd1;
  localparam logic [1:0]  TARGET_RST    = 2'd0;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 3;

  // pattern step codes
  localparam logic [2:0] DL_IDLE    = 3'd0;
  localparam logic [2:0] DL_S1      = 3'd1;
  localparam logic [2:0] DL_S2      = 3'd2;
  localparam logic [2:0] DL_S3      = 3'd3;
  localparam logic [2:0] DL_DONE    = 3'd4;
  localparam logic [2:0] DL_BLOCKED = 3'd5;
  localparam logic [1:0] APP_IDLE    = 2'd0;
  localparam logic [1:0] APP_S1      = 2'd1;
  localparam logic [1:0] APP_DONE    = 2'd2;
  localparam logic [1:0] APP_BLOCKED = 2'd3;

  typedef enum logic [2:0] {
    CFG_HOLD   = 3'd0,
    CFG_SETTLE = 3'd1,
    CFG_IDLE   = 3'd2,
    CFG_WAKE   = 3'd3,
    CFG_TARGET = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_LINE = 2'd0,
    OP_TICK = 2'd1,
    OP_WAKE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DL_RESET = 3'd1,
    EV_APP_RESET = 3'd2,
    EV_RELEASED = 3'd3,
    EV_CLEARED  = 3'd4
  } evt_e;

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] settle_ms;
    logic [15:0] idle_ms;
    logic [15:0] wake_ms;
    logic [1:0]  target_interface;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       link_ready;
    logic [1:0] interface_req;
    logic       dtr;
    logic       rts;
  } item_t;

  typedef struct packed {
    logic       boot_select_level;
    logic       chip_enable_level;
    logic       wake_pull_low;
    logic [2:0] event_res;
  } res_t;

endpackage

@@ hdl/drs_if.sv @@
// valid/ready channel interfaces for line events and sequencer results
`timescale 1ns / 1ps

interface drs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       link_ready;
  logic [1:0] interface_req;
  logic       dtr;
  logic       rts;

  modport source (output valid, output operation, output link_ready,
                  output interface_req, output dtr, output rts, input ready);
  modport sink   (input valid, input operation, input link_ready,
                  input interface_req, input dtr, input rts, output ready);
endinterface

interface drs_res_if;
  logic       valid;
  logic       ready;
  logic       boot_select_level;
  logic       chip_enable_level;
  logic       wake_pull_low;
  logic [2:0] event_res;

  modport source (output valid, output boot_select_level, output chip_enable_level,
                  output wake_pull_low, output event_res, input ready);
  modport sink   (input valid, input boot_select_level, input chip_enable_level,
                  input wake_pull_low, input event_res, output ready);
endinterface

@@ hdl/dtr_rts_auto_reset_sequencer.sv @@
// top level of the dtr/rts auto-reset sequencer
`timescale 1ns / 1ps

// usage
//   item_i carries line-state changes, 1 ms ticks and wake requests from the
//   host bridge; res_o returns one result per item with the boot-select,
//   chip-enable and wake levels after that item plus an event code
//   cfg_we_i/cfg_idx_i/cfg_data_i write hold, settle, idle, wake times and the
//   watched interface; write them only while no transfer is in flight
// timing
//   an item is registered in the input register on its transfer, evaluated
//   against the pattern state while it sits there and lands in the result
//   register when that one is free, from which its result is offered on res_o
//   one item per cycle sustained while res_o does not stall: the state update
//   is a single short combinational pass between the input register and the result register
// reset
//   rst_ni clears both stages, both pattern counters and the timers; the boot
//   pin resets high and enable low (target held in reset)
// back-pressure
//   while res_o is stalled the result register holds; the input register
//   still takes one more item, then item_i.ready drops until res_o moves
module dtr_rts_auto_reset_sequencer #(
  parameter int unsigned TIMER_BITS = drs_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  drs_item_if.sink                       item_i,
  drs_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [drs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import drs_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res_d, res_q;
  logic  s1_vld_q, s1_vld_d;
  logic  out_vld_q, out_vld_d;
  logic  in_xfer, adv;

  drs_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // evaluation stage moves into the result register when that one is free
  assign adv          = s1_vld_q && (!out_vld_q || res_o.ready);
  assign item_i.ready = !s1_vld_q || adv;
  assign in_xfer      = item_i.valid && item_i.ready;

  always_comb begin
    s1_vld_d  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_vld_q);
    out_vld_d = adv ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation     <= item_i.operation;
      item_q.link_ready    <= item_i.link_ready;
      item_q.interface_req <= item_i.interface_req;
      item_q.dtr           <= item_i.dtr;
      item_q.rts           <= item_i.rts;
    end
    if (adv) res_q <= res_d;
  end

  drs_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .upd_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign res_o.valid             = out_vld_q;
  assign res_o.boot_select_level = res_q.boot_select_level;
  assign res_o.chip_enable_level = res_q.chip_enable_level;
  assign res_o.wake_pull_low     = res_q.wake_pull_low;
  assign res_o.event_res         = res_q.event_res;

endmodule

@@ hdl/drs_cfg_regs.sv @@
// configuration register file of the sequencer
`timescale 1ns / 1ps

module drs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [drs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output drs_pkg::cfg_t                  cfg_o
);
  import drs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HOLD:   cfg_d.hold_ms          = cfg_data_i;
        CFG_SETTLE: cfg_d.settle_ms        = cfg_data_i;
        CFG_IDLE:   cfg_d.idle_ms          = cfg_data_i;
        CFG_WAKE:   cfg_d.wake_ms          = cfg_data_i;
        CFG_TARGET: cfg_d.target_interface = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms          <= HOLD_MS_RST;
      cfg_q.settle_ms        <= SETTLE_MS_RST;
      cfg_q.idle_ms          <= IDLE_MS_RST;
      cfg_q.wake_ms          <= WAKE_MS_RST;
      cfg_q.target_interface <= TARGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/drs_core.sv @@
// pattern state, timers and pin levels updated once per transfer
`timescale 1ns / 1ps

module drs_core #(
  parameter int unsigned TIMER_BITS = drs_pkg::TIMER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  drs_pkg::item_t item_i,
  input  drs_pkg::cfg_t  cfg_i,
  output drs_pkg::res_t  res_o
);
  import drs_pkg::*;

  localparam logic [31:0] TMax = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

  // saturating load of a 16 bit setting into a timer
  function automatic logic [TIMER_BITS-1:0] tload(input logic [15:0] v);
    logic [31:0] ext;
    ext = {16'b0, v};
    if (ext > TMax) ext = TMax;
    return ext[TIMER_BITS-1:0];
  endfunction

  logic [2:0]            dl_q, dl_d;
  logic [1:0]            app_q, app_d;
  logic                  last_dtr_q, last_dtr_d, last_rts_q, last_rts_d;
  logic                  pulse_q, pulse_d, wake_q, wake_d;
  logic                  boot_q, boot_d, en_q, en_d;
  logic [TIMER_BITS-1:0] rem_q, rem_d, wrem_q, wrem_d;
  logic                  d_lvl, r_lvl, rexp, wexp;
  logic [2:0]            evt;

  always_comb begin
    dl_d       = dl_q;
    app_d      = app_q;
    last_dtr_d = last_dtr_q;
    last_rts_d = last_rts_q;
    pulse_d    = pulse_q;
    wake_d     = wake_q;
    boot_d     = boot_q;
    en_d       = en_q;
    rem_d      = rem_q;
    wrem_d     = wrem_q;
    evt        = EV_NONE;
    d_lvl      = item_i.dtr | last_dtr_q;
    r_lvl      = item_i.rts | last_rts_q;
    rexp       = (rem_q == '0);
    wexp       = (wrem_q == '0);

    unique case (op_e'(item_i.operation))
      OP_LINE: begin
        if (item_i.link_ready && item_i.interface_req == cfg_i.target_interface) begin
          if (dl_d == DL_IDLE && d_lvl && r_lvl)  dl_d = DL_S1;
          if (dl_d == DL_S1 && d_lvl && !r_lvl)   dl_d = DL_S2;
          if (dl_d == DL_S2 && !d_lvl && r_lvl)   dl_d = DL_S3;
          if (dl_d == DL_S3 && d_lvl && r_lvl) begin
            dl_d    = DL_DONE;
            boot_d  = 1'b0;
            en_d    = 1'b0;
            pulse_d = 1'b1;
            rem_d   = tload(cfg_i.hold_ms);
            evt     = EV_DL_RESET;
          end
          if (app_d == APP_IDLE && !d_lvl && r_lvl) app_d = APP_S1;
          if (app_d == APP_S1 && !d_lvl && !r_lvl) begin
            app_d   = APP_DONE;
            boot_d  = 1'b1;
            en_d    = 1'b0;
            pulse_d = 1'b1;
            rem_d   = tload(cfg_i.hold_ms);
            evt     = EV_APP_RESET;
          end
          last_dtr_d = item_i.dtr;
          last_rts_d = item_i.rts;
          // outside a pulse the shared timer restarts as the idle timer
          if (!pulse_d) rem_d = tload(cfg_i.idle_ms);
        end
      end
      OP_TICK: begin
        if (!rexp) rem_d = rem_q - TIMER_BITS'(1);
        if (!wexp) wrem_d = wrem_q - TIMER_BITS'(1);
        if (item_i.link_ready) begin
          if ((dl_q != DL_IDLE || pulse_q) && rexp) begin
            if (pulse_q) begin
              en_d    = 1'b1;
              pulse_d = 1'b0;
              dl_d    = DL_BLOCKED;
              app_d   = APP_BLOCKED;
              rem_d   = tload(cfg_i.settle_ms);
              evt     = EV_RELEASED;
            end else begin
              dl_d   = DL_IDLE;
              app_d  = APP_IDLE;
              boot_d = 1'b1;
              en_d   = 1'b1;
              evt    = EV_CLEARED;
            end
          end
          if (wake_q && wexp) wake_d = 1'b0;
        end
      end
      OP_WAKE: begin
        wake_d = 1'b1;
        wrem_d = tload(cfg_i.wake_ms);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q       <= DL_IDLE;
      app_q      <= APP_IDLE;
      last_dtr_q <= 1'b0;
      last_rts_q <= 1'b0;
      pulse_q    <= 1'b0;
      wake_q     <= 1'b0;
      boot_q     <= 1'b1;
      en_q       <= 1'b0;
      rem_q      <= '0;
      wrem_q     <= '0;
    end else if (upd_i) begin
      dl_q       <= dl_d;
      app_q      <= app_d;
      last_dtr_q <= last_dtr_d;
      last_rts_q <= last_rts_d;
      pulse_q    <= pulse_d;
      wake_q     <= wake_d;
      boot_q     <= boot_d;
      en_q       <= en_d;
      rem_q      <= rem_d;
      wrem_q     <= wrem_d;
    end
  end

  assign res_o.boot_select_level = boot_d;
  assign res_o.chip_enable_level = en_d;
  assign res_o.wake_pull_low     = wake_d;
  assign res_o.event_res         = evt;

endmodule

@@ hdl/drs_checker.sv @@
// port-level checks on sequencer results, bound to the top level
`timescale 1ns / 1ps

module drs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       boot_lvl_i,
  input logic       en_lvl_i,
  input logic       wake_lvl_i,
  input logic [2:0] evt_i
);
  import drs_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(boot_lvl_i) && $stable(en_lvl_i)
      && $stable(wake_lvl_i) && $stable(evt_i))
    else $error("result changed while stalled");

  a_dl_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evt_i == EV_DL_RESET |-> !boot_lvl_i && !en_lvl_i)
    else $error("download reset without boot low and enable low");

  a_app_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evt_i == EV_APP_RESET |-> boot_lvl_i && !en_lvl_i)
    else $error("app reset without boot high and enable low");

  a_release_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (evt_i == EV_RELEASED || evt_i == EV_CLEARED) |-> en_lvl_i)
    else $error("release or clear left enable low");

  a_clear_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evt_i == EV_CLEARED |-> boot_lvl_i)
    else $error("pattern clear left boot select low");

endmodule

bind dtr_rts_auto_reset_sequencer drs_checker u_drs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .boot_lvl_i  (res_o.boot_select_level),
  .en_lvl_i    (res_o.chip_enable_level),
  .wake_lvl_i  (res_o.wake_pull_low),
  .evt_i       (res_o.event_res)
);
